// ===== sv/swhc_pkg.sv =====
`default_nettype none
package swhc_pkg;

  localparam int TIME_W  = 31;
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 32;
  localparam int WIN_W   = 9;

  localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(300);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

  localparam logic KIND_HIT = 1'b0;

  // APB: 32-bit data, register i at byte address 4*i
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-3:0] REG_WINDOW = '0;

  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic [COUNT_W-1:0] c;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FULL,
    ST_EVICT,
    ST_HOLD
  } swhc_state_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == TOTAL_MAX) ? v : v + TOTAL_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== sv/swhc_in_if.sv =====
`default_nettype none
interface swhc_in_if import swhc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] timestamp;

  modport source (output valid, output kind, output timestamp, input ready);
  modport sink (input valid, input kind, input timestamp, output ready);
endinterface
`default_nettype wire

// ===== sv/swhc_out_if.sv =====
`default_nettype none
interface swhc_out_if import swhc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] hits_in_window;

  modport source (output valid, output hits_in_window, input ready);
  modport sink (input valid, input hits_in_window, output ready);
endinterface
`default_nettype wire

// ===== sv/swhc_ram.sv =====
`default_nettype none
module swhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/sliding_window_hit_counter.sv =====
// Channel  Dir  Port  Payload
// -------  ---  ----  ----------------------------------------------
// item     in   req   kind (0 hit, 1 query), timestamp[30:0]
// result   out  rsp   hits_in_window[31:0], one word per item
// config   in   APB   window_seconds at byte address 0
//
// A hit in the newest second finishes in EXEC. A new-second hit or a query goes
// on to EVICT; the eviction walk reads one bucket a cycle from the RAM's single
// read port. A push into a full queue passes through FULL first.
// Reset (rst, synchronous) empties the queue and the total; bucket RAM is not
// cleared. The result sits in an output register, so a new word is taken while
// rsp is stalled; the block waits only when its next result finds it full.
`default_nettype none
module sliding_window_hit_counter import swhc_pkg::*; #(
  parameter int BUCKETS = 512
) (
  input  wire logic                clk,
  input  wire logic                rst,
  swhc_in_if.sink                  req,
  swhc_out_if.source               rsp,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic      [APB_DW-1:0]   prdata,
  output logic                     pready
);

  localparam int AW = $clog2(BUCKETS);
  localparam int OW = $clog2(BUCKETS + 1);
  localparam int EW = $bits(entry_t);

  swhc_state_t        state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [AW-1:0]      tail, tail_next;
  logic [OW-1:0]      occ, occ_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [WIN_W-1:0]   window;
  logic [TIME_W-1:0]  newest_time, newest_time_next;
  logic [COUNT_W-1:0] newest_count, newest_count_next;
  logic               kind_r, kind_r_next;
  logic [TIME_W-1:0]  now_r, now_r_next;
  logic               fwd, fwd_next;
  logic               out_valid, out_valid_next;
  logic [TOTAL_W-1:0] out_data, out_data_next;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  entry_t             wentry, rentry, head_entry;
  logic [EW-1:0]      ram_rdata;

  logic [AW-1:0]      head_inc, tail_inc, prev_tail;
  logic [TIME_W-1:0]  age;
  logic               old_enough;
  logic [TOTAL_W-1:0] sub_total;
  logic               finish;
  logic               cfg_wr;

  swhc_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign rentry = entry_t'(ram_rdata);

  assign head_inc  = (head == AW'(BUCKETS - 1)) ? '0 : head + AW'(1);
  assign tail_inc  = (tail == AW'(BUCKETS - 1)) ? '0 : tail + AW'(1);
  assign prev_tail = (tail == '0) ? AW'(BUCKETS - 1) : tail - AW'(1);

  // the bucket pushed into an empty queue was read in the same cycle it was written
  always_comb begin
    if (fwd) begin
      head_entry.t = now_r;
      head_entry.c = COUNT_W'(1);
    end else begin
      head_entry = rentry;
    end
  end

  assign age        = (now_r >= head_entry.t) ? now_r - head_entry.t : '0;
  assign old_enough = age >= TIME_W'(window);
  assign sub_total  = (total >= TOTAL_W'(head_entry.c)) ? total - TOTAL_W'(head_entry.c) : '0;

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.hits_in_window = out_data;

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    occ_next          = occ;
    total_next        = total;
    newest_time_next  = newest_time;
    newest_count_next = newest_count;
    kind_r_next       = kind_r;
    now_r_next        = now_r;
    fwd_next          = fwd;
    out_valid_next    = out_valid && !rsp.ready;
    out_data_next     = out_data;
    we                = 1'b0;
    waddr             = tail;
    wentry.t          = now_r;
    wentry.c          = COUNT_W'(1);
    raddr             = head;
    finish            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          kind_r_next = req.kind;
          now_r_next  = req.timestamp;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fwd_next = 1'b0;
        if (kind_r == KIND_HIT && occ != '0 && newest_time == now_r) begin
          // same second: bump the newest bucket unless it is saturated
          if (newest_count != COUNT_MAX) begin
            newest_count_next = newest_count + COUNT_W'(1);
            we                = 1'b1;
            waddr             = prev_tail;
            wentry.c          = newest_count + COUNT_W'(1);
            total_next        = sat_inc(total);
          end
          finish = 1'b1;
        end else if (kind_r == KIND_HIT) begin
          if (occ == OW'(BUCKETS)) begin
            state_next = ST_FULL;
          end else begin
            we                = 1'b1;
            tail_next         = tail_inc;
            occ_next          = occ + OW'(1);
            total_next        = sat_inc(total);
            newest_time_next  = now_r;
            newest_count_next = COUNT_W'(1);
            fwd_next          = (occ == '0);
            state_next        = ST_EVICT;
          end
        end else begin
          state_next = ST_EVICT;
        end
      end
      ST_FULL: begin
        // drop the oldest bucket, then push into its slot
        total_next        = sat_inc(sub_total);
        head_next         = head_inc;
        we                = 1'b1;
        tail_next         = tail_inc;
        newest_time_next  = now_r;
        newest_count_next = COUNT_W'(1);
        raddr             = head_inc;
        state_next        = ST_EVICT;
      end
      ST_EVICT: begin
        if (occ != '0 && old_enough) begin
          total_next = sub_total;
          head_next  = head_inc;
          occ_next   = occ - OW'(1);
          raddr      = head_inc;
          fwd_next   = 1'b0;
        end else begin
          finish = 1'b1;
        end
      end
      ST_HOLD: begin
        finish = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (!out_valid || rsp.ready) begin
        out_valid_next = 1'b1;
        out_data_next  = total_next;
        state_next     = ST_IDLE;
      end else begin
        state_next = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      total     <= '0;
      fwd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      occ       <= occ_next;
      total     <= total_next;
      fwd       <= fwd_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    newest_time  <= newest_time_next;
    newest_count <= newest_count_next;
    kind_r       <= kind_r_next;
    now_r        <= now_r_next;
    out_data     <= out_data_next;
  end

  // configuration
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_wr && paddr[APB_AW-1:2] == REG_WINDOW) begin
      window <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1:2] == REG_WINDOW) ? APB_DW'(window) : '0;

endmodule
`default_nettype wire

// ===== tb/sv/swhc_hit_window_checker.sv =====
`timescale 1ns / 1ps
module swhc_hit_window_checker import swhc_pkg::*; #(
  parameter int BUCKETS = 512
) (
  input  wire logic              clk,
  input  wire logic              rst,
  swhc_in_if                     req,
  swhc_out_if                    rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  input  wire logic [APB_DW-1:0] prdata,
  output int                     mismatch_count,
  output int                     totals_owed
);

  logic [TIME_W-1:0]  slot_time  [BUCKETS];
  logic [COUNT_W-1:0] slot_count [BUCKETS];
  int unsigned        head;
  int unsigned        tail;
  int unsigned        held;
  logic [TOTAL_W-1:0] total;
  logic [WIN_W-1:0]   window;
  logic [TOTAL_W-1:0] expected_totals [$];
  logic [TOTAL_W-1:0] want;

  function automatic void drop_oldest();
    total = (total >= TOTAL_W'(slot_count[head])) ? total - TOTAL_W'(slot_count[head]) : '0;
    head  = (head + 1) % BUCKETS;
    held  = held - 1;
  endfunction

  // walk from the oldest bucket; a bucket newer than now has age 0
  function automatic void expire(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    while (held > 0) begin
      age = (now >= slot_time[head]) ? now - slot_time[head] : '0;
      if (age < TIME_W'(window))
        break;
      drop_oldest();
    end
  endfunction

  function automatic logic [TOTAL_W-1:0] predict_hits(input logic kind,
                                                      input logic [TIME_W-1:0] now);
    int unsigned newest;
    if (kind == KIND_HIT) begin
      newest = (tail == 0) ? BUCKETS - 1 : tail - 1;
      if (held > 0 && slot_time[newest] == now) begin
        // a full bucket drops the hit
        if (slot_count[newest] != COUNT_MAX) begin
          slot_count[newest] = slot_count[newest] + 1'b1;
          if (total != TOTAL_MAX)
            total = total + 1'b1;
        end
      end else begin
        if (held >= BUCKETS)
          drop_oldest();
        slot_time[tail]  = now;
        slot_count[tail] = COUNT_W'(1);
        tail = (tail + 1) % BUCKETS;
        held = held + 1;
        if (total != TOTAL_MAX)
          total = total + 1'b1;
        expire(now);
      end
    end else begin
      expire(now);
    end
    return total;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      window = WINDOW_RESET;
      head   = 0;
      tail   = 0;
      held   = 0;
      total  = '0;
      expected_totals.delete();
      totals_owed = 0;
    end else begin
      if (psel && penable && pready && paddr[APB_AW-1:2] == REG_WINDOW) begin
        if (pwrite) begin
          window = pwdata[WIN_W-1:0];
        end else if (prdata[WIN_W-1:0] !== window) begin
          $error("window_seconds: expected %0d, got %0d", window, prdata[WIN_W-1:0]);
          mismatch_count++;
        end
      end
      // retire before predicting: a word taken now belongs to an older item
      if (rsp.valid && rsp.ready) begin
        if (expected_totals.size() == 0) begin
          $error("hits_in_window: expected none, got %0d", rsp.hits_in_window);
          mismatch_count++;
        end else begin
          want = expected_totals[0];
          expected_totals.delete(0);
          if (rsp.hits_in_window !== want) begin
            $error("hits_in_window: expected %0d, got %0d", want, rsp.hits_in_window);
            mismatch_count++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_totals.insert(expected_totals.size(),
                               predict_hits(req.kind, req.timestamp));
      totals_owed = expected_totals.size();
    end
  end

endmodule

// ===== tb/sv/tb_sliding_window_hit_counter.sv =====
`timescale 1ns / 1ps
module tb_sliding_window_hit_counter;
  import swhc_pkg::*;

  localparam int                BUCKETS      = 512;
  localparam logic              KIND_QUERY   = ~KIND_HIT;
  localparam logic [APB_AW-3:0] REG_SPARE    = 1'b1;
  localparam logic [TIME_W-1:0] TIME_MAX     = '1;
  localparam int                RANDOM_WORDS = 320;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  int                mismatch_count;
  int                totals_owed;
  bit                req_idle_on  = 1'b1;
  bit                rsp_stall_on = 1'b1;
  bit                rsp_took     = 1'b0;
  int                stall_left   = 0;

  swhc_in_if  req_ch ();
  swhc_out_if rsp_ch ();

  sliding_window_hit_counter #(.BUCKETS(BUCKETS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  swhc_hit_window_checker #(.BUCKETS(BUCKETS)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .mismatch_count (mismatch_count),
    .totals_owed    (totals_owed)
  );

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: fresh random stall after every word taken while rsp_stall_on is set
  always @(posedge clk) rsp_took <= rsp_ch.valid && rsp_ch.ready;

  always @(negedge clk) begin
    if (rsp_took)
      stall_left = rsp_stall_on ? $urandom_range(0, 11) : 0;
    if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic kind, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = req_idle_on ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.timestamp <= stamp;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (totals_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] win);
    drain();
    apb_access(1'b1, {REG_WINDOW, 2'b00}, APB_DW'(win));
    apb_access(1'b0, {REG_WINDOW, 2'b00}, '0);
  endtask

  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] t,
                                                   input int unsigned span);
    int unsigned         r;
    int unsigned         back;
    logic [TIME_W:0]     up;
    logic [TIME_W-1:0]   nxt;
    r   = $urandom_range(0, 99);
    up  = {1'b0, t};
    nxt = t;
    if (r < 40)
      up = {1'b0, t};
    else if (r < 75)
      up = up + $urandom_range(1, 3);
    else if (r < 87)
      up = up + $urandom_range(0, span);
    else if (r < 93)
      up = up + $urandom_range(0, 1 << 20);
    if (r < 93) begin
      nxt = up[TIME_W] ? TIME_MAX : up[TIME_W-1:0];
    end else if (r < 97) begin
      back = $urandom_range(1, 10);
      nxt  = (t > TIME_W'(back)) ? t - TIME_W'(back) : '0;
    end else if (r < 99) begin
      nxt = TIME_W'($urandom());
    end else begin
      nxt = TIME_MAX - TIME_W'($urandom_range(0, 3));
    end
    return nxt;
  endfunction

  initial begin
    logic [TIME_W-1:0] now_s;
    logic [WIN_W-1:0]  win;
    int                sent;
    int                phase;
    int                n;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_HIT;
    req_ch.timestamp = '0;
    rsp_ch.ready     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset window readback, then edge cases at the default window
    apb_access(1'b0, {REG_WINDOW, 2'b00}, '0);
    send_word(KIND_QUERY, '0);
    send_word(KIND_HIT, '0);
    send_word(KIND_HIT, '0);
    send_word(KIND_HIT, TIME_W'(5));
    send_word(KIND_QUERY, TIME_W'(299));
    send_word(KIND_QUERY, TIME_W'(300));
    send_word(KIND_HIT, TIME_W'(2));
    send_word(KIND_QUERY, TIME_W'(304));
    send_word(KIND_HIT, TIME_MAX);
    send_word(KIND_QUERY, TIME_MAX);
    send_word(KIND_QUERY, '0);
    drain();
    // write to an unmapped register must leave the window alone
    apb_access(1'b1, {REG_SPARE, 2'b00}, '1);
    apb_access(1'b0, {REG_WINDOW, 2'b00}, '0);
    set_window('0);
    send_word(KIND_HIT, TIME_W'(10));
    send_word(KIND_HIT, TIME_W'(10));
    send_word(KIND_QUERY, TIME_W'(10));
    set_window(WIN_W'(1));
    send_word(KIND_HIT, TIME_W'(20));
    send_word(KIND_HIT, TIME_W'(20));
    send_word(KIND_HIT, TIME_W'(21));
    send_word(KIND_QUERY, TIME_W'(21));
    send_word(KIND_QUERY, TIME_W'(22));

    // alternating seconds never age out, so the queue fills and wraps
    set_window('1);
    for (int i = 0; i < 560; i++)
      send_word(KIND_HIT, TIME_W'(5000 + (i % 2)));
    send_word(KIND_QUERY, TIME_W'(5600));

    now_s = '0;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0: win = WIN_W'(1);
        1: win = '1;
        2: win = '0;
        default: begin
          case ($urandom_range(0, 2))
            0:       win = WIN_W'($urandom_range(1, 8));
            1:       win = WIN_W'($urandom_range(9, 100));
            default: win = WIN_W'($urandom_range(0, 511));
          endcase
        end
      endcase
      set_window(win);
      req_idle_on  = ($urandom_range(0, 3) != 0);
      rsp_stall_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 120);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0)
          drain();
        now_s = next_stamp(now_s, int'(win) + 20);
        send_word(($urandom_range(0, 9) < 7) ? KIND_HIT : KIND_QUERY, now_s);
        sent++;
      end
      phase++;
    end

    drain();
    repeat (16) @(negedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
